[sv/mia_pkg.sv]
// Package for the MIPS32 integer ALU with HI/LO.
// Holds group codes, function codes and shared widths; no dependencies.
package mia_pkg;
  localparam int XLEN = 32;
  localparam int KIND_W = 3;
  localparam int REG_W = 5;

  localparam logic [2:0] KIND_IMM   = 3'd0;
  localparam logic [2:0] KIND_CLZ   = 3'd1;
  localparam logic [2:0] KIND_ALU   = 3'd2;
  localparam logic [2:0] KIND_SHIFT = 3'd3;
  localparam logic [2:0] KIND_EXT   = 3'd4;
  localparam logic [2:0] KIND_BSWAP = 3'd5;
  localparam logic [2:0] KIND_MULDIV = 3'd6;

  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_XORI  = 6'd14;
  localparam logic [5:0] OP_LUI   = 6'd15;

  localparam logic [5:0] FN_CLZ  = 6'd22;
  localparam logic [5:0] FN_CLO  = 6'd23;

  localparam logic [5:0] FN_MOVZ = 6'd10;
  localparam logic [5:0] FN_MOVN = 6'd11;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;
  localparam logic [5:0] FN_MAX  = 6'd44;
  localparam logic [5:0] FN_MIN  = 6'd45;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6;
  localparam logic [5:0] FN_SRAV = 6'd7;

  localparam logic [5:0] FN_EXT  = 6'd0;
  localparam logic [5:0] FN_INS  = 6'd4;

  localparam logic [9:0] LOW_WSBH = 10'h0A0;
  localparam logic [9:0] LOW_WSBW = 10'h0E0;
  localparam logic [4:0] SA_SEB    = 5'd16;
  localparam logic [4:0] SA_SEH    = 5'd24;
  localparam logic [4:0] SA_BITREV = 5'd20;

  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_MADD  = 6'd28;
  localparam logic [5:0] FN_MADDU = 6'd29;
  localparam logic [5:0] FN_MSUB  = 6'd46;
  localparam logic [5:0] FN_MSUBU = 6'd47;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] instruction_word;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } in_item_t;

  typedef struct packed {
    logic        write_gpr;
    logic [4:0]  dest_index;
    logic [31:0] write_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        unhandled;
  } out_item_t;
endpackage

[sv/mia_if.sv]
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; payload type given as a type parameter.
interface mia_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/mips32_integer_alu_hilo.sv]
// Single-cycle groups give a registered result in the cycle after the input transfer;
// mult/multu/madd/maddu/msub/msubu run 32 shift-add steps on the shared
// 33-bit adder, 2 accumulate steps and 1 output step; div/divu run 32
// restoring steps, sign fix-up, output step. Throughput: one single-cycle item a cycle
// while out_ch.ready is high; in_ready is low through a multi-cycle operation and while
// a result waits without out_ch.ready. Reset (synchronous, rst_n low) clears HI, LO,
// the sequencer and the output valid flag.
module mips32_integer_alu_hilo (
  input logic clk,
  input logic rst_n,
  mia_if.sink   in_ch,
  mia_if.source out_ch
);
  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACCL = 3'd2;
  localparam logic [2:0] ST_ACCH = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DFIX = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] opa_r, opa_nxt, opb_r, opb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_a_r, neg_a_nxt, neg_b_r, neg_b_nxt;
  logic        cy_r, cy_nxt;
  logic [5:0]  fn_r, fn_nxt;
  mia_pkg::out_item_t res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  // shared adder
  logic [32:0] add_a, add_b, add_sum;
  logic        add_cin;
  assign add_sum = add_a + add_b + {32'd0, add_cin};

  mia_pkg::in_item_t it;
  logic [5:0]  op, fn;
  logic [4:0]  f_rs, f_rt, f_rd, f_sa;
  logic [31:0] a, b, simm, uimm;
  logic        take;
  assign it   = in_ch.payload;
  assign op   = it.instruction_word[31:26];
  assign f_rs = it.instruction_word[25:21];
  assign f_rt = it.instruction_word[20:16];
  assign f_rd = it.instruction_word[15:11];
  assign f_sa = it.instruction_word[10:6];
  assign fn   = it.instruction_word[5:0];
  assign a    = it.rs_value;
  assign b    = it.rt_value;
  assign simm = {{16{it.instruction_word[15]}}, it.instruction_word[15:0]};
  assign uimm = {16'd0, it.instruction_word[15:0]};
  assign in_ch.ready  = (state_r == ST_IDLE) && (!ovalid_r || out_ch.ready);
  assign take   = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = ovalid_r;
  assign out_ch.payload = res_r;

  // single-cycle helpers
  function automatic logic [31:0] clz32(input logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n = 6'd32;
    hit = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 6'(31 - i);
        hit = 1'b1;
      end
    end
    return {26'd0, n};
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} >> s;
    return d[31:0];
  endfunction

  function automatic logic [31:0] bitrev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    return r;
  endfunction

  function automatic logic slt_s(input logic [31:0] x, input logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // decode and evaluate the single-cycle groups
  logic        c_wr, c_bad, c_long;
  logic [4:0]  c_dst;
  logic [31:0] c_val, c_hi, c_lo, mask, src;
  logic [5:0]  size;
  always_comb begin
    c_wr = 1'b1;
    c_bad = 1'b0;
    c_long = 1'b0;
    c_dst = f_rd;
    c_val = '0;
    c_hi = hi_r;
    c_lo = lo_r;
    size = {1'b0, f_rd} + 6'd1;
    mask = size[5] ? 32'hFFFF_FFFF : ((32'd1 << size[4:0]) - 32'd1);
    src  = mask >> f_sa;
    case (it.kind)
      mia_pkg::KIND_IMM: begin
        c_dst = f_rt;
        case (op)
          mia_pkg::OP_ADDI, mia_pkg::OP_ADDIU: c_val = a + simm;
          mia_pkg::OP_SLTI:  c_val = {31'd0, slt_s(a, simm)};
          mia_pkg::OP_SLTIU: c_val = {31'd0, a < simm};
          mia_pkg::OP_ANDI:  c_val = a & uimm;
          mia_pkg::OP_ORI:   c_val = a | uimm;
          mia_pkg::OP_XORI:  c_val = a ^ uimm;
          mia_pkg::OP_LUI:   c_val = {it.instruction_word[15:0], 16'd0};
          default: begin c_wr = 1'b0; c_bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_CLZ: begin
        if (fn == mia_pkg::FN_CLZ) c_val = clz32(a);
        else if (fn == mia_pkg::FN_CLO) c_val = clz32(~a);
        else begin c_wr = 1'b0; c_bad = 1'b1; end
      end
      mia_pkg::KIND_ALU: begin
        case (fn)
          mia_pkg::FN_MOVZ: begin c_wr = (b == 32'd0); c_val = a; end
          mia_pkg::FN_MOVN: begin c_wr = (b != 32'd0); c_val = a; end
          mia_pkg::FN_ADD, mia_pkg::FN_ADDU: c_val = a + b;
          mia_pkg::FN_SUB, mia_pkg::FN_SUBU: c_val = a - b;
          mia_pkg::FN_AND:  c_val = a & b;
          mia_pkg::FN_OR:   c_val = a | b;
          mia_pkg::FN_XOR:  c_val = a ^ b;
          mia_pkg::FN_NOR:  c_val = ~(a | b);
          mia_pkg::FN_SLT:  c_val = {31'd0, slt_s(a, b)};
          mia_pkg::FN_SLTU: c_val = {31'd0, a < b};
          mia_pkg::FN_MAX:  c_val = slt_s(b, a) ? a : b;
          mia_pkg::FN_MIN:  c_val = slt_s(a, b) ? a : b;
          default: begin c_wr = 1'b0; c_bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_SHIFT: begin
        case (fn)
          mia_pkg::FN_SLL:  c_val = b << f_sa;
          mia_pkg::FN_SRL:  c_val = (f_rs == 5'd1) ? ror32(b, f_sa) : (b >> f_sa);
          mia_pkg::FN_SRA:  c_val = 32'($signed(b) >>> f_sa);
          mia_pkg::FN_SLLV: c_val = b << a[4:0];
          mia_pkg::FN_SRLV: c_val = (f_sa == 5'd1) ? ror32(b, a[4:0]) : (b >> a[4:0]);
          mia_pkg::FN_SRAV: c_val = 32'($signed(b) >>> a[4:0]);
          default: begin c_wr = 1'b0; c_bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_EXT: begin
        c_dst = f_rt;
        if (fn == mia_pkg::FN_EXT) c_val = (a >> f_sa) & mask;
        else if (fn == mia_pkg::FN_INS)
          c_val = (b & ~(src << f_sa)) | ((a & src) << f_sa);
        else begin c_wr = 1'b0; c_bad = 1'b1; end
      end
      mia_pkg::KIND_BSWAP: begin
        if (it.instruction_word[9:0] == mia_pkg::LOW_WSBH)
          c_val = {b[23:16], b[31:24], b[7:0], b[15:8]};
        else if (it.instruction_word[9:0] == mia_pkg::LOW_WSBW)
          c_val = {b[7:0], b[15:8], b[23:16], b[31:24]};
        else if (f_sa == mia_pkg::SA_SEB) c_val = {{24{b[7]}}, b[7:0]};
        else if (f_sa == mia_pkg::SA_SEH) c_val = {{16{b[15]}}, b[15:0]};
        else if (f_sa == mia_pkg::SA_BITREV) c_val = bitrev32(b);
        else begin c_wr = 1'b0; c_bad = 1'b1; end
      end
      mia_pkg::KIND_MULDIV: begin
        c_wr = 1'b0;
        case (fn)
          mia_pkg::FN_MFHI: begin c_wr = 1'b1; c_val = hi_r; end
          mia_pkg::FN_MFLO: begin c_wr = 1'b1; c_val = lo_r; end
          mia_pkg::FN_MTHI: c_hi = a;
          mia_pkg::FN_MTLO: c_lo = a;
          mia_pkg::FN_MULT, mia_pkg::FN_MULTU, mia_pkg::FN_MADD, mia_pkg::FN_MADDU,
          mia_pkg::FN_MSUB, mia_pkg::FN_MSUBU, mia_pkg::FN_DIV, mia_pkg::FN_DIVU:
            c_long = 1'b1;
          default: c_bad = 1'b1;
        endcase
      end
      default: begin c_wr = 1'b0; c_bad = 1'b1; end
    endcase
    if (c_dst == 5'd0) c_wr = 1'b0;
    if (!c_wr) begin
      c_dst = 5'd0;
      c_val = '0;
    end
  end

  // signed forms of multiply/divide take magnitudes, fix the sign at the end
  logic is_signed, is_div, sgn_a, sgn_b;
  logic [31:0] mag_a, mag_b;
  always_comb begin
    is_signed = (fn == mia_pkg::FN_MULT) || (fn == mia_pkg::FN_MADD) ||
                (fn == mia_pkg::FN_MSUB) || (fn == mia_pkg::FN_DIV);
    is_div = (fn == mia_pkg::FN_DIV) || (fn == mia_pkg::FN_DIVU);
    sgn_a = is_signed && a[31];
    sgn_b = is_signed && b[31];
    mag_a = sgn_a ? (32'd0 - a) : a;
    mag_b = sgn_b ? (32'd0 - b) : b;
  end

  // product after sign fix (two's complement of 64-bit magnitude)
  logic        prod_neg;
  logic [63:0] prod;
  assign prod_neg = neg_a_r ^ neg_b_r;
  assign prod = prod_neg ? (64'd0 - acc_r) : acc_r;

  // sequencer and datapath
  always_comb begin
    state_nxt = state_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    acc_nxt = acc_r;
    neg_a_nxt = neg_a_r;
    neg_b_nxt = neg_b_r;
    cy_nxt = cy_r;
    fn_nxt = fn_r;
    res_nxt = res_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    add_a = '0;
    add_b = '0;
    add_cin = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (c_long) begin
            fn_nxt = fn;
            opa_nxt = mag_a;
            opb_nxt = mag_b;
            neg_a_nxt = sgn_a;
            neg_b_nxt = sgn_b;
            cnt_nxt = '0;
            if (is_div) begin
              acc_nxt = {32'd0, mag_a};
              state_nxt = ST_DIV;
            end else begin
              acc_nxt = {32'd0, mag_b};
              state_nxt = ST_MUL;
            end
          end else begin
            hi_nxt = c_hi;
            lo_nxt = c_lo;
            res_nxt = '{write_gpr: c_wr, dest_index: c_dst, write_value: c_val,
                        hi_value: c_hi, lo_value: c_lo, unhandled: c_bad};
            ovalid_nxt = 1'b1;
          end
        end
      end
      ST_MUL: begin
        // shift-add: acc = {high, multiplier}; add multiplicand when lsb set
        add_a = {1'b0, acc_r[63:32]};
        add_b = acc_r[0] ? {1'b0, opa_r} : 33'd0;
        acc_nxt = {add_sum, acc_r[31:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_ACCL;
      end
      ST_ACCL: begin
        // low half of accumulate; the high half of the sign-fixed product is saved in opa
        opa_nxt = prod[63:32];
        if (fn_r == mia_pkg::FN_MADD || fn_r == mia_pkg::FN_MADDU) begin
          add_a = {1'b0, lo_r};
          add_b = {1'b0, prod[31:0]};
        end else if (fn_r == mia_pkg::FN_MSUB || fn_r == mia_pkg::FN_MSUBU) begin
          add_a = {1'b0, lo_r};
          add_b = {1'b0, ~prod[31:0]};
          add_cin = 1'b1;
        end else begin
          add_a = {1'b0, prod[31:0]};
        end
        lo_nxt = add_sum[31:0];
        cy_nxt = add_sum[32];
        state_nxt = ST_ACCH;
      end
      ST_ACCH: begin
        if (fn_r == mia_pkg::FN_MADD || fn_r == mia_pkg::FN_MADDU) begin
          add_a = {1'b0, hi_r};
          add_b = {1'b0, opa_r};
          add_cin = cy_r;
        end else if (fn_r == mia_pkg::FN_MSUB || fn_r == mia_pkg::FN_MSUBU) begin
          add_a = {1'b0, hi_r};
          add_b = {1'b0, ~opa_r};
          add_cin = cy_r;
        end else begin
          add_a = {1'b0, opa_r};
        end
        hi_nxt = add_sum[31:0];
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        // restoring step: acc = {remainder, dividend}; shifted remainder is 33 bits
        add_a = acc_r[63:31];
        add_b = {1'b0, ~opb_r};
        add_cin = 1'b1;
        if (add_sum[32]) acc_nxt = {add_sum[31:0], acc_r[30:0], 1'b1};
        else acc_nxt = {acc_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_DFIX;
      end
      ST_DFIX: begin
        if (opb_r == 32'd0) begin
          lo_nxt = '0;
          hi_nxt = (fn_r == mia_pkg::FN_DIV) ? (neg_a_r ? (32'd0 - opa_r) : opa_r) : 32'd0;
        end else begin
          lo_nxt = prod_neg ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
          hi_nxt = neg_a_r ? (32'd0 - acc_r[63:32]) : acc_r[63:32];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          res_nxt = '{write_gpr: 1'b0, dest_index: 5'd0, write_value: 32'd0,
                      hi_value: hi_r, lo_value: lo_r, unhandled: 1'b0};
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hi_r <= '0;
      lo_r <= '0;
      ovalid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    acc_r <= acc_nxt;
    neg_a_r <= neg_a_nxt;
    neg_b_r <= neg_b_nxt;
    cy_r <= cy_nxt;
    fn_r <= fn_nxt;
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> (ovalid_r && $stable(res_r)))
    else $error("result dropped");
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && res_r.write_gpr) |-> (res_r.dest_index != 5'd0))
    else $error("write to zero register");
  a_hilo_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_DIV) |=> ($stable(hi_r) && $stable(lo_r)))
    else $error("HI/LO moved mid-operation");
`endif
endmodule

[sim/tb_mips32_integer_alu_hilo.sv]
`timescale 1ns / 1ps
// Testbench for mips32_integer_alu_hilo: directed table plus random instructions, each
// transfer checked against an in-bench ALU/HI-LO predictor. Depends on mia_pkg, mia_if, the DUT.
module tb_mips32_integer_alu_hilo;
  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  mia_if #(.T(mia_pkg::in_item_t)) in_ch ();
  mia_if #(.T(mia_pkg::out_item_t)) out_ch ();

  mips32_integer_alu_hilo DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] model_hi = '0;
  logic [31:0] model_lo = '0;
  mia_pkg::out_item_t pending_results[$];

  typedef struct {
    mia_pkg::in_item_t  item;
    bit                 typed;
    mia_pkg::out_item_t result;
  } stim_row_t;

  function automatic logic [31:0] make_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                            logic [4:0] rd, logic [4:0] sa, logic [5:0] fn);
    return {op, rs, rt, rd, sa, fn};
  endfunction

  function automatic bit signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] count_lead(logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && !v[31 - n]) n++;
    return 32'(n);
  endfunction

  function automatic logic [31:0] rotate_right(logic [31:0] v, logic [4:0] s);
    return (s == 5'd0) ? v : ((v >> s) | (v << (6'd32 - s)));
  endfunction

  // Compute one result and advance the HI/LO copy.
  function automatic mia_pkg::out_item_t alu_predict(mia_pkg::in_item_t it);
    mia_pkg::out_item_t r;
    logic [31:0] w, a, b, val, simm, uimm, mask, src;
    logic [4:0] rs, rt, rd, sa, dst;
    logic [5:0] fn;
    logic [63:0] acc, sp, up;
    logic [31:0] ua, ub, q, rm;
    bit wr, bad;
    w = it.instruction_word; a = it.rs_value; b = it.rt_value;
    rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6]; fn = w[5:0];
    simm = {{16{w[15]}}, w[15:0]}; uimm = {16'h0, w[15:0]};
    wr = 1'b0; bad = 1'b0; dst = rd; val = '0;
    case (it.kind)
      mia_pkg::KIND_IMM: begin
        dst = rt; wr = 1'b1;
        case (w[31:26])
          mia_pkg::OP_ADDI, mia_pkg::OP_ADDIU: val = a + simm;
          mia_pkg::OP_SLTI: val = {31'd0, signed_lt(a, simm)};
          mia_pkg::OP_SLTIU: val = {31'd0, a < simm};
          mia_pkg::OP_ANDI: val = a & uimm;
          mia_pkg::OP_ORI: val = a | uimm;
          mia_pkg::OP_XORI: val = a ^ uimm;
          mia_pkg::OP_LUI: val = uimm << 16;
          default: begin wr = 1'b0; bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_CLZ: begin
        wr = 1'b1;
        if (fn == mia_pkg::FN_CLZ) val = count_lead(a);
        else if (fn == mia_pkg::FN_CLO) val = count_lead(~a);
        else begin wr = 1'b0; bad = 1'b1; end
      end
      mia_pkg::KIND_ALU: begin
        wr = 1'b1;
        case (fn)
          mia_pkg::FN_MOVZ: begin wr = (b == 32'd0); val = a; end
          mia_pkg::FN_MOVN: begin wr = (b != 32'd0); val = a; end
          mia_pkg::FN_ADD, mia_pkg::FN_ADDU: val = a + b;
          mia_pkg::FN_SUB, mia_pkg::FN_SUBU: val = a - b;
          mia_pkg::FN_AND: val = a & b;
          mia_pkg::FN_OR: val = a | b;
          mia_pkg::FN_XOR: val = a ^ b;
          mia_pkg::FN_NOR: val = ~(a | b);
          mia_pkg::FN_SLT: val = {31'd0, signed_lt(a, b)};
          mia_pkg::FN_SLTU: val = {31'd0, a < b};
          mia_pkg::FN_MAX: val = signed_lt(b, a) ? a : b;
          mia_pkg::FN_MIN: val = signed_lt(a, b) ? a : b;
          default: begin wr = 1'b0; bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_SHIFT: begin
        wr = 1'b1;
        case (fn)
          mia_pkg::FN_SLL: val = b << sa;
          mia_pkg::FN_SRL: val = (rs == 5'd1) ? rotate_right(b, sa) : (b >> sa);
          mia_pkg::FN_SRA: val = $signed(b) >>> sa;
          mia_pkg::FN_SLLV: val = b << a[4:0];
          mia_pkg::FN_SRLV: val = (sa == 5'd1) ? rotate_right(b, a[4:0]) : (b >> a[4:0]);
          mia_pkg::FN_SRAV: val = $signed(b) >>> a[4:0];
          default: begin wr = 1'b0; bad = 1'b1; end
        endcase
      end
      mia_pkg::KIND_EXT: begin
        mask = (rd == 5'd31) ? 32'hFFFF_FFFF : ((32'd1 << (rd + 5'd1)) - 32'd1);
        dst = rt; wr = 1'b1;
        if (fn == mia_pkg::FN_EXT) val = (a >> sa) & mask;
        else if (fn == mia_pkg::FN_INS) begin
          src = mask >> sa;
          val = (b & ~(src << sa)) | ((a & src) << sa);
        end else begin wr = 1'b0; bad = 1'b1; end
      end
      mia_pkg::KIND_BSWAP: begin
        wr = 1'b1;
        if (w[9:0] == mia_pkg::LOW_WSBH) val = {b[23:16], b[31:24], b[7:0], b[15:8]};
        else if (w[9:0] == mia_pkg::LOW_WSBW) val = {b[7:0], b[15:8], b[23:16], b[31:24]};
        else if (sa == mia_pkg::SA_SEB) val = {{24{b[7]}}, b[7:0]};
        else if (sa == mia_pkg::SA_SEH) val = {{16{b[15]}}, b[15:0]};
        else if (sa == mia_pkg::SA_BITREV) val = {<<{b}};
        else begin wr = 1'b0; bad = 1'b1; end
      end
      mia_pkg::KIND_MULDIV: begin
        acc = {model_hi, model_lo};
        sp = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        up = {32'h0, a} * {32'h0, b};
        case (fn)
          mia_pkg::FN_MFHI: begin wr = 1'b1; val = model_hi; end
          mia_pkg::FN_MTHI: model_hi = a;
          mia_pkg::FN_MFLO: begin wr = 1'b1; val = model_lo; end
          mia_pkg::FN_MTLO: model_lo = a;
          mia_pkg::FN_MULT, mia_pkg::FN_MULTU, mia_pkg::FN_MADD, mia_pkg::FN_MADDU,
          mia_pkg::FN_MSUB, mia_pkg::FN_MSUBU: begin
            case (fn)
              mia_pkg::FN_MULT: acc = sp;
              mia_pkg::FN_MULTU: acc = up;
              mia_pkg::FN_MADD: acc = acc + sp;
              mia_pkg::FN_MADDU: acc = acc + up;
              mia_pkg::FN_MSUB: acc = acc - sp;
              default: acc = acc - up;
            endcase
            {model_hi, model_lo} = acc;
          end
          mia_pkg::FN_DIV: begin
            if (b == 32'd0) begin model_lo = '0; model_hi = a; end
            else begin
              ua = a[31] ? -a : a;
              ub = b[31] ? -b : b;
              q = ua / ub; rm = ua % ub;
              model_lo = (a[31] != b[31]) ? -q : q;
              model_hi = a[31] ? -rm : rm;
            end
          end
          mia_pkg::FN_DIVU: begin
            if (b == 32'd0) begin model_lo = '0; model_hi = '0; end
            else begin model_lo = a / b; model_hi = a % b; end
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (dst == 5'd0) wr = 1'b0;
    if (!wr) begin dst = '0; val = '0; end
    r.write_gpr = wr; r.dest_index = dst; r.write_value = val;
    r.hi_value = model_hi; r.lo_value = model_lo; r.unhandled = bad;
    return r;
  endfunction

  // Random instruction: mostly valid codes of a random group, some noise.
  function automatic mia_pkg::in_item_t random_instr();
    mia_pkg::in_item_t it;
    logic [5:0] fn;
    logic [5:0] imm_ops[8] = '{mia_pkg::OP_ADDI, mia_pkg::OP_ADDIU, mia_pkg::OP_SLTI,
                              mia_pkg::OP_SLTIU, mia_pkg::OP_ANDI, mia_pkg::OP_ORI,
                              mia_pkg::OP_XORI, mia_pkg::OP_LUI};
    logic [5:0] alu_fns[14] = '{mia_pkg::FN_MOVZ, mia_pkg::FN_MOVN, mia_pkg::FN_ADD,
                               mia_pkg::FN_ADDU, mia_pkg::FN_SUB, mia_pkg::FN_SUBU,
                               mia_pkg::FN_AND, mia_pkg::FN_OR, mia_pkg::FN_XOR,
                               mia_pkg::FN_NOR, mia_pkg::FN_SLT, mia_pkg::FN_SLTU,
                               mia_pkg::FN_MAX, mia_pkg::FN_MIN};
    logic [5:0] sh_fns[6] = '{mia_pkg::FN_SLL, mia_pkg::FN_SRL, mia_pkg::FN_SRA,
                             mia_pkg::FN_SLLV, mia_pkg::FN_SRLV, mia_pkg::FN_SRAV};
    logic [5:0] md_fns[14] = '{mia_pkg::FN_MFHI, mia_pkg::FN_MTHI, mia_pkg::FN_MFLO,
                              mia_pkg::FN_MTLO, mia_pkg::FN_MULT, mia_pkg::FN_MULTU,
                              mia_pkg::FN_DIV, mia_pkg::FN_DIVU, mia_pkg::FN_MADD,
                              mia_pkg::FN_MADDU, mia_pkg::FN_MSUB, mia_pkg::FN_MSUBU,
                              mia_pkg::FN_MFHI, mia_pkg::FN_MFLO};
    logic [4:0] sas[3] = '{mia_pkg::SA_SEB, mia_pkg::SA_SEH, mia_pkg::SA_BITREV};
    it.kind = 3'($urandom_range(0, 6));
    it.instruction_word = $urandom;
    it.rs_value = $urandom;
    it.rt_value = $urandom;
    case ($urandom_range(0, 7))
      0: it.rs_value = 32'h8000_0000;
      1: it.rt_value = '0;
      2: it.rt_value = 32'hFFFF_FFFF;
      3: it.rs_value = $urandom_range(0, 3) - 2;
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 3) == 0) it.kind = 3'd7;
      return it;
    end
    case (it.kind)
      mia_pkg::KIND_IMM: it.instruction_word[31:26] = imm_ops[$urandom_range(0, 7)];
      mia_pkg::KIND_CLZ:
        it.instruction_word[5:0] = $urandom_range(0, 1) ? mia_pkg::FN_CLZ : mia_pkg::FN_CLO;
      mia_pkg::KIND_ALU: it.instruction_word[5:0] = alu_fns[$urandom_range(0, 13)];
      mia_pkg::KIND_SHIFT: begin
        it.instruction_word[5:0] = sh_fns[$urandom_range(0, 5)];
        if ($urandom_range(0, 1)) it.instruction_word[25:21] = 5'd1;
        if ($urandom_range(0, 2) == 0) it.instruction_word[10:6] = 5'($urandom_range(0, 1));
      end
      mia_pkg::KIND_EXT:
        it.instruction_word[5:0] = $urandom_range(0, 1) ? mia_pkg::FN_EXT : mia_pkg::FN_INS;
      mia_pkg::KIND_BSWAP: begin
        case ($urandom_range(0, 2))
          0: it.instruction_word[9:0] =
               $urandom_range(0, 1) ? mia_pkg::LOW_WSBH : mia_pkg::LOW_WSBW;
          default: it.instruction_word[10:6] = sas[$urandom_range(0, 2)];
        endcase
      end
      default: it.instruction_word[5:0] = md_fns[$urandom_range(0, 13)];
    endcase
    return it;
  endfunction

  function automatic mia_pkg::out_item_t typed_result(bit wr, logic [4:0] dst,
                                                      logic [31:0] val, logic [31:0] hi,
                                                      logic [31:0] lo, bit bad);
    mia_pkg::out_item_t r;
    r.write_gpr = wr; r.dest_index = dst; r.write_value = val;
    r.hi_value = hi; r.lo_value = lo; r.unhandled = bad;
    return r;
  endfunction

  stim_row_t directed_rows[$];

  // Build the directed table; typed results only where obvious.
  task automatic build_table();
    stim_row_t row;
    row.typed = 1'b0;
    // mfhi right after reset: HI and LO zero
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd3, 5'd0, mia_pkg::FN_MFHI), 32'd0, 32'd0};
    row.typed = 1'b1;
    row.result = typed_result(1'b1, 5'd3, 32'd0, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_IMM,
                 make_word(mia_pkg::OP_LUI, 5'd0, 5'd31, 5'd0, 5'd0, 6'd0) | 32'hFFFF,
                 '1, '1};
    row.result = typed_result(1'b1, 5'd31, 32'hFFFF_0000, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    // zero destination: no write
    row.item = '{mia_pkg::KIND_ALU, make_word(6'd0, 5'd1, 5'd2, 5'd0, 5'd0, mia_pkg::FN_ADD),
                 32'h7FFF_FFFF, 32'd1};
    row.result = typed_result(1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    // unhandled kind
    row.item = '{3'd7, '1, '1, '1};
    row.result = typed_result(1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    directed_rows.push_back(row);
    // clz of zero, clo of all ones
    row.item = '{mia_pkg::KIND_CLZ, make_word(6'd0, 5'd0, 5'd0, 5'd4, 5'd0, mia_pkg::FN_CLZ),
                 32'd0, 32'd0};
    row.result = typed_result(1'b1, 5'd4, 32'd32, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_CLZ, make_word(6'd0, 5'd0, 5'd0, 5'd4, 5'd0, mia_pkg::FN_CLO),
                 '1, 32'd0};
    row.result = typed_result(1'b1, 5'd4, 32'd32, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    // divu by zero, div by zero
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd0, 5'd0, mia_pkg::FN_DIVU),
                 32'h1234_5678, 32'd0};
    row.result = typed_result(1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd0, 5'd0, mia_pkg::FN_DIV),
                 32'hDEAD_BEEF, 32'd0};
    row.result = typed_result(1'b0, 5'd0, 32'd0, 32'hDEAD_BEEF, 32'd0, 1'b0);
    directed_rows.push_back(row);
    // most negative over minus one
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd0, 5'd0, mia_pkg::FN_DIV),
                 32'h8000_0000, '1};
    row.result = typed_result(1'b0, 5'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b0);
    directed_rows.push_back(row);
    row.typed = 1'b0;
    row.item = '{mia_pkg::KIND_IMM,
                 make_word(mia_pkg::OP_ADDI, 5'd0, 5'd7, 5'd0, 5'd0, 6'd0) | 32'h8000,
                 32'h8000_0000, 32'd0};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_IMM,
                 make_word(mia_pkg::OP_SLTIU, 5'd0, 5'd7, 5'd0, 5'd0, 6'd0) | 32'hFFFF,
                 '1, 32'd0};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_ALU, make_word(6'd0, 5'd0, 5'd0, 5'd9, 5'd0, mia_pkg::FN_MAX),
                 32'h8000_0000, 32'h7FFF_FFFF};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_ALU, make_word(6'd0, 5'd0, 5'd0, 5'd9, 5'd0, mia_pkg::FN_MIN),
                 32'h8000_0000, 32'h7FFF_FFFF};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_ALU,
                 make_word(6'd0, 5'd0, 5'd0, 5'd9, 5'd0, mia_pkg::FN_MOVZ),
                 32'h55AA, 32'd1};
    directed_rows.push_back(row);
    // rotate by zero and rotate right
    row.item = '{mia_pkg::KIND_SHIFT,
                 make_word(6'd0, 5'd1, 5'd0, 5'd2, 5'd0, mia_pkg::FN_SRL),
                 32'd0, 32'h8000_0001};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_SHIFT,
                 make_word(6'd0, 5'd0, 5'd0, 5'd2, 5'd1, mia_pkg::FN_SRLV),
                 32'd31, 32'h8000_0001};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_SHIFT,
                 make_word(6'd0, 5'd0, 5'd0, 5'd2, 5'd31, mia_pkg::FN_SRA),
                 32'd0, 32'h8000_0000};
    directed_rows.push_back(row);
    // full-width ext, reversed ins fields
    row.item = '{mia_pkg::KIND_EXT,
                 make_word(6'd0, 5'd0, 5'd5, 5'd31, 5'd0, mia_pkg::FN_EXT), '1, 32'd0};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_EXT,
                 make_word(6'd0, 5'd0, 5'd5, 5'd2, 5'd8, mia_pkg::FN_INS),
                 '1, 32'hA5A5_A5A5};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_BSWAP,
                 make_word(6'd0, 5'd0, 5'd0, 5'd6, mia_pkg::SA_BITREV, 6'd0),
                 32'd0, 32'h0000_0001};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_BSWAP,
                 {22'h0, mia_pkg::LOW_WSBH} | make_word(6'd0, 5'd0, 5'd0, 5'd6, 5'd0, 6'd0),
                 32'd0, 32'h1234_5678};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd0, 5'd0, mia_pkg::FN_MULT),
                 32'h8000_0000, 32'h8000_0000};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd0, 5'd0, mia_pkg::FN_MSUBU), '1, '1};
    directed_rows.push_back(row);
    row.item = '{mia_pkg::KIND_MULDIV,
                 make_word(6'd0, 5'd0, 5'd0, 5'd8, 5'd0, mia_pkg::FN_MFLO), 32'd0, 32'd0};
    directed_rows.push_back(row);
  endtask

  // Push one instruction through the input channel.
  task automatic send_instr(mia_pkg::in_item_t it, bit typed, mia_pkg::out_item_t typed_res);
    mia_pkg::out_item_t r;
    // idle with valid low for a random number of cycles
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while (!no_idle && $urandom_range(0, 99) < 33);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = alu_predict(it);
    if (typed && r !== typed_res) begin
      $display("%0t table row mismatch: typed %h predictor %h", $time, typed_res, r);
      failed = 1'b1;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // Result side: random stalls, field compare against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    mia_pkg::out_item_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.write_gpr !== want.write_gpr || got.dest_index !== want.dest_index ||
            got.write_value !== want.write_value || got.hi_value !== want.hi_value ||
            got.lo_value !== want.lo_value || got.unhandled !== want.unhandled) begin
          $display("%0t mismatch: expected wr=%b rd=%0d val=%h hi=%h lo=%h bad=%b", $time,
                   want.write_gpr, want.dest_index, want.write_value, want.hi_value,
                   want.lo_value, want.unhandled);
          $display("%0t           actual wr=%b rd=%0d val=%h hi=%h lo=%h bad=%b", $time,
                   got.write_gpr, got.dest_index, got.write_value, got.hi_value,
                   got.lo_value, got.unhandled);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int drain;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    build_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[i])
      send_instr(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 550);
      // hold the sender until all results are back
      if (n == 700) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      send_instr(random_instr(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/mia_pkg.sv
sv/mia_if.sv
sv/mips32_integer_alu_hilo.sv
sim/tb_mips32_integer_alu_hilo.sv
